### rtl/bilinear_grid_upsampler_assert.svh
// assertion macros shared by the upsampler rtl
// expects signals named clk and arst_n in the including module
`ifndef BILINEAR_GRID_UPSAMPLER_ASSERT_SVH
`define BILINEAR_GRID_UPSAMPLER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define BGU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define BGU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/bgu_pkg.sv
// shared constants, types and helper functions of the bilinear grid upsampler
// no dependencies
package bgu_pkg;

	localparam int MAX_COLS    = 4096;
	localparam int MAX_RATE    = 8;
	localparam int COL_W       = $clog2(MAX_COLS);
	localparam int ROW_W       = 12;
	localparam int CFG_COLS_W  = 13;
	localparam int RATE_W      = 4;
	localparam int SUB_W       = (MAX_RATE > 1) ? $clog2(MAX_RATE) : 1;
	localparam int H_W         = 16;
	localparam int UP_W        = 15;
	localparam int DEN_W       = 7;
	localparam int NUM_W       = 26;
	localparam int MAG_W       = 22;
	localparam int RECIP_SHIFT = 22;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int DIV_ONE     = 1 << RECIP_SHIFT;
	localparam int CFG_IDX_W   = 2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_RATE = 2'd0;
	localparam cfg_idx_t REG_COLS = 2'd1;

	// one input sample after the line store read was issued
	typedef struct packed {
		logic                    valid;
		logic signed [H_W-1:0]   h4;
		logic [COL_W-1:0]        col;
		logic [ROW_W-1:0]        row;
	} cell_req_t;

	// one interpolation point handed to the divider
	typedef struct packed {
		logic signed [NUM_W-1:0] num;
		logic [RATE_W-1:0]       rate;
		logic [UP_W-1:0]         row;
		logic [UP_W-1:0]         col;
		logic                    last;
	} sub_item_t;

	function automatic logic [RATE_W-1:0] eff_rate(input logic [RATE_W-1:0] r);
		logic [RATE_W-1:0] v;
		v = r;
		if (r == '0)
			v = RATE_W'(1);
		else if (r > RATE_W'(MAX_RATE))
			v = RATE_W'(MAX_RATE);
		return v;
	endfunction

	function automatic logic [COL_W:0] eff_cols(input logic [CFG_COLS_W-1:0] c);
		logic [COL_W:0] v;
		if (c < CFG_COLS_W'(2))
			v = (COL_W+1)'(2);
		else if (c > CFG_COLS_W'(MAX_COLS))
			v = (COL_W+1)'(MAX_COLS);
		else
			v = (COL_W+1)'(c);
		return v;
	endfunction

	// floor(2^RECIP_SHIFT / (r*r))
	function automatic logic [RECIP_W-1:0] recip_of(input logic [RATE_W-1:0] r);
		logic [RECIP_W-1:0] v;
		unique case (r)
			4'd2:    v = RECIP_W'(DIV_ONE / 4);
			4'd3:    v = RECIP_W'(DIV_ONE / 9);
			4'd4:    v = RECIP_W'(DIV_ONE / 16);
			4'd5:    v = RECIP_W'(DIV_ONE / 25);
			4'd6:    v = RECIP_W'(DIV_ONE / 36);
			4'd7:    v = RECIP_W'(DIV_ONE / 49);
			4'd8:    v = RECIP_W'(DIV_ONE / 64);
			default: v = RECIP_W'(DIV_ONE);
		endcase
		return v;
	endfunction

endpackage

### rtl/bgu_line_store.sv
// previous-row line store: one synchronous read-first port
// depends on bgu_pkg
module bgu_line_store import bgu_pkg::*; (
	input  logic                  clk,
	input  logic                  we,
	input  logic [COL_W-1:0]      addr,
	input  logic signed [H_W-1:0] wdata,
	output logic signed [H_W-1:0] rdata
);

	logic signed [H_W-1:0] mem [MAX_COLS];
	logic signed [H_W-1:0] rdata_q;

	// read returns the old entry, the new sample replaces it
	always_ff @(posedge clk) begin
		if (we) begin
			rdata_q   <= mem[addr];
			mem[addr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/bgu_cell_seq.sv
// cell setup and sub-point sequencer: builds the bilinear coefficients of a cell
// and steps the numerator incrementally; depends on bgu_pkg and the assert header
`include "bilinear_grid_upsampler_assert.svh"

module bgu_cell_seq import bgu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_req_t             req,
	input  logic signed [H_W-1:0] up_height,
	input  logic [RATE_W-1:0]     rate,
	input  logic                  en,
	output logic                  busy,
	output logic                  sub_valid,
	output sub_item_t             sub
);

	logic signed [H_W-1:0]       ul_q, left_q;
	logic                        busy_q;
	logic signed [NUM_W-1:0]     t_row_q, step_q, num_q, c_q, d_q;
	logic [SUB_W-1:0]            bi_q, bj_q;
	logic [RATE_W-1:0]           rate_q;
	logic [UP_W-1:0]             base_r_q, base_c_q;

	logic signed [H_W:0]         a10, a01;
	logic signed [H_W+1:0]       a11;
	logic [DEN_W-1:0]            den;
	logic signed [H_W+DEN_W:0]   a_full;
	logic signed [H_W+RATE_W+1:0] b_full, c_full;
	logic [RATE_W+ROW_W-1:0]     br_full;
	logic [RATE_W+COL_W-1:0]     bc_full;
	logic                        emit;
	logic [SUB_W-1:0]            last_sub;
	logic                        sub_last;

	always_comb begin
		a10     = (H_W+1)'(up_height) - (H_W+1)'(ul_q);
		a01     = (H_W+1)'(left_q) - (H_W+1)'(ul_q);
		a11     = (H_W+2)'(ul_q) - (H_W+2)'(up_height) - (H_W+2)'(left_q)
		        + (H_W+2)'(req.h4);
		den     = DEN_W'(rate * rate);
		a_full  = ul_q * $signed({1'b0, den});
		b_full  = a10 * $signed({1'b0, rate});
		c_full  = a01 * $signed({1'b0, rate});
		br_full = rate * (req.row - ROW_W'(1));
		bc_full = rate * (req.col - COL_W'(1));
		emit    = (req.row != '0) && (req.col != '0);
	end

	assign last_sub = SUB_W'(rate_q - RATE_W'(1));
	assign sub_last = (bi_q == last_sub) && (bj_q == last_sub);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ul_q   <= '0;
			left_q <= '0;
			busy_q <= 1'b0;
		end else begin
			if (req.valid) begin
				ul_q   <= up_height;
				left_q <= req.h4;
				busy_q <= emit;
			end else if (busy_q && en && sub_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			t_row_q  <= NUM_W'(a_full);
			num_q    <= NUM_W'(a_full);
			step_q   <= NUM_W'(b_full);
			c_q      <= NUM_W'(c_full);
			d_q      <= NUM_W'(a11);
			bi_q     <= '0;
			bj_q     <= '0;
			rate_q   <= rate;
			base_r_q <= br_full[UP_W-1:0];
			base_c_q <= UP_W'(bc_full);
		end else if (busy_q && en) begin
			// row-major walk: along a row add the row slope, at row end move down
			if (bj_q == last_sub) begin
				bj_q    <= '0;
				bi_q    <= bi_q + SUB_W'(1);
				t_row_q <= t_row_q + c_q;
				num_q   <= t_row_q + c_q;
				step_q  <= step_q + d_q;
			end else begin
				bj_q  <= bj_q + SUB_W'(1);
				num_q <= num_q + step_q;
			end
		end
	end

	assign busy      = busy_q;
	assign sub_valid = busy_q;
	assign sub.num   = num_q;
	assign sub.rate  = rate_q;
	assign sub.row   = base_r_q + UP_W'(bi_q);
	assign sub.col   = base_c_q + UP_W'(bj_q);
	assign sub.last  = sub_last;

	`BGU_ASSERT_IMPL(a_load_idle, req.valid, !busy_q, "cell request while sequence busy")
	`BGU_ASSERT_IMPL(a_sub_range, busy_q, (bi_q <= last_sub) && (bj_q <= last_sub), "sub-index beyond rate")
	`BGU_ASSERT_NEXT(a_last_ends, busy_q && en && sub_last, !busy_q, "sequence runs past last point")

endmodule

### rtl/bgu_div.sv
// division of the numerator by rate squared, truncated toward zero, via a
// reciprocal multiply and one correction step; holds the output register; depends on bgu_pkg
module bgu_div import bgu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  sub_valid,
	input  sub_item_t             sub,
	output logic                  out_valid,
	output logic signed [H_W-1:0] up_height,
	output logic [UP_W-1:0]       up_row,
	output logic [UP_W-1:0]       up_col,
	output logic                  last_of_cell
);

	logic                    v_s1, v_s2, out_valid_q;
	logic                    neg_s1, neg_s2;
	logic [MAG_W-1:0]        mag_s1, mag_s2, q_s2;
	logic [RECIP_W-1:0]      recip_s1;
	logic [DEN_W-1:0]        den_s1, den_s2;
	logic [UP_W-1:0]         row_s1, row_s2, col_s1, col_s2;
	logic                    last_s1, last_s2;
	logic signed [H_W-1:0]   height_q;
	logic [UP_W-1:0]         row_q, col_q;
	logic                    last_q;

	logic signed [NUM_W-1:0]  abs_full;
	logic [MAG_W+RECIP_W-1:0] prod;
	logic [MAG_W+DEN_W-1:0]   qd;
	logic [MAG_W:0]           rem;
	logic [MAG_W-1:0]         q_fix;
	logic [MAG_W:0]           q_signed;

	always_comb begin
		abs_full = sub.num[NUM_W-1] ? -sub.num : sub.num;
		prod     = mag_s1 * recip_s1;
		qd       = q_s2 * den_s2;
		rem      = (MAG_W+1)'(mag_s2) - (MAG_W+1)'(qd);
		// estimate is low by at most one
		q_fix    = (rem >= (MAG_W+1)'(den_s2)) ? q_s2 + MAG_W'(1) : q_s2;
		q_signed = neg_s2 ? -(MAG_W+1)'(q_fix) : (MAG_W+1)'(q_fix);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= sub_valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1   <= sub.num[NUM_W-1];
			mag_s1   <= abs_full[MAG_W-1:0];
			recip_s1 <= recip_of(sub.rate);
			den_s1   <= DEN_W'(sub.rate * sub.rate);
			row_s1   <= sub.row;
			col_s1   <= sub.col;
			last_s1  <= sub.last;

			neg_s2   <= neg_s1;
			mag_s2   <= mag_s1;
			q_s2     <= prod[RECIP_SHIFT +: MAG_W];
			den_s2   <= den_s1;
			row_s2   <= row_s1;
			col_s2   <= col_s1;
			last_s2  <= last_s1;

			height_q <= q_signed[H_W-1:0];
			row_q    <= row_s2;
			col_q    <= col_s2;
			last_q   <= last_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign up_height    = height_q;
	assign up_row       = row_q;
	assign up_col       = col_q;
	assign last_of_cell = last_q;

endmodule

### rtl/bilinear_grid_upsampler.sv
// top level of the bilinear grid upsampler: configuration registers, raster
// position, line store, cell sequencer and divider; depends on bgu_pkg and all bgu_ modules
//
// Input channel (in_valid / in_stall / height): one signed elevation sample per
// transfer, raster order, grid_cols (held to 2..4096) samples to a row. A sample at
// row >= 1 and column >= 1 closes a 2x2 cell and yields the square of rate_factor
// (held to 1..8) results in row-major sub-order; others only update the stored row.
// Output channel (out_valid / out_stall / up_height, up_row, up_col,
// last_of_cell): one interpolated point per transfer, last_of_cell on the
// final point of a cell.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
// rate_factor, index 1 is grid_cols; other indexes are dropped. cfg_ready is
// always high; write only while the block is idle.
// Timing: the sample is registered with its line store read, the sequencer then
// loads the cell, and each point passes the divider registers. The input stalls
// during the line store read and, for a sample that closes a cell, while the
// sequencer emits one point per cycle as long as the output is not stalled.
// Reset clears positions and neighbors and loads rate 2 and 3601 columns; the
// line store is not cleared. A stalled output freezes the divider registers and
// the sequencer stepping, so the input stays stalled while a cell is pending.
`include "bilinear_grid_upsampler_assert.svh"

module bilinear_grid_upsampler import bgu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [H_W-1:0] height,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [H_W-1:0] up_height,
	output logic [UP_W-1:0]       up_row,
	output logic [UP_W-1:0]       up_col,
	output logic                  last_of_cell,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_COLS_W-1:0] cfg_data
);

	logic [RATE_W-1:0]     rate_q;
	logic [CFG_COLS_W-1:0] cols_q;
	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	logic                  s1_valid_q;
	logic signed [H_W-1:0] h4_s1;
	logic [COL_W-1:0]      col_s1;
	logic [ROW_W-1:0]      row_s1;

	logic                  accept;
	logic                  en;
	logic                  seq_busy;
	logic                  sub_valid;
	sub_item_t             sub;
	cell_req_t             req;
	logic signed [H_W-1:0] up_rd;
	logic [COL_W:0]        col_next;

	assign cfg_ready = 1'b1;
	assign in_stall  = seq_busy || s1_valid_q;
	assign accept    = in_valid && !in_stall;
	assign en        = !out_valid || !out_stall;
	assign col_next  = (COL_W+1)'(col_q) + (COL_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_W'(2);
			cols_q <= CFG_COLS_W'(3601);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RATE: rate_q <= cfg_data[RATE_W-1:0];
				REG_COLS: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
			if (accept) begin
				// also wraps when the column count was lowered below the position
				if (col_next >= eff_cols(cols_q)) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_next[COL_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			h4_s1  <= height;
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

	assign req.valid = s1_valid_q;
	assign req.h4    = h4_s1;
	assign req.col   = col_s1;
	assign req.row   = row_s1;

	bgu_line_store u_line_store (
		.clk   (clk),
		.we    (accept),
		.addr  (col_q),
		.wdata (height),
		.rdata (up_rd)
	);

	bgu_cell_seq u_cell_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.up_height (up_rd),
		.rate      (eff_rate(rate_q)),
		.en        (en),
		.busy      (seq_busy),
		.sub_valid (sub_valid),
		.sub       (sub)
	);

	bgu_div u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.sub_valid    (sub_valid),
		.sub          (sub),
		.out_valid    (out_valid),
		.up_height    (up_height),
		.up_row       (up_row),
		.up_col       (up_col),
		.last_of_cell (last_of_cell)
	);

	`BGU_ASSERT_IMPL(a_setup_idle, s1_valid_q, !seq_busy, "line store data arrives while sequencer busy")

endmodule

### tb/tb_bilinear_grid_upsampler.sv
`timescale 1ns / 100ps
// self-checking testbench of the bilinear grid upsampler: drives elevation samples and
// register writes, predicts every interpolated point and checks the output stream
// depends on bgu_pkg and the bilinear_grid_upsampler rtl

module tb_bilinear_grid_upsampler;
	import bgu_pkg::*;

	localparam int       CLK_HALF    = 6;
	localparam int       SETTLE_CYC  = 16;
	localparam int       MAX_REPORTS = 100;
	localparam int       RANDOM_ITEMS = 200;
	localparam int       FILL_COLS   = 40;
	localparam cfg_idx_t REG_SPARE_A = 2'd2;
	localparam cfg_idx_t REG_SPARE_B = 2'd3;

	typedef enum int {HM_UNIFORM, HM_EXTREME, HM_WALK} height_mode_t;

	typedef struct packed {
		logic signed [H_W-1:0] h;
		logic [UP_W-1:0]       row;
		logic [UP_W-1:0]       col;
		logic                  last;
	} up_point_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic signed [H_W-1:0] height = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic signed [H_W-1:0] up_height;
	logic [UP_W-1:0]       up_row;
	logic [UP_W-1:0]       up_col;
	logic                  last_of_cell;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index = REG_RATE;
	logic [CFG_COLS_W-1:0] cfg_data = '0;

	up_point_t expected_points[$];
	int        error_count = 0;
	int        hold_left = 0;
	int        burst_left = 0;
	int        walk_h = 0;

	// shadow of the block state, advanced on every accepted sample
	logic signed [H_W-1:0] prev_row_mem [0:MAX_COLS-1];
	logic signed [H_W-1:0] left_h = '0;
	logic signed [H_W-1:0] upleft_h = '0;
	logic [COL_W-1:0]      raster_col = '0;
	logic [ROW_W-1:0]      raster_row = '0;
	logic [RATE_W-1:0]     rate_reg = 4'd2;
	logic [CFG_COLS_W-1:0] cols_reg = 13'd3601;

	bilinear_grid_upsampler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.height       (height),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.up_height    (up_height),
		.up_row       (up_row),
		.up_col       (up_col),
		.last_of_cell (last_of_cell),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// interpolate the cell closed by sample h4 and step the raster position
	task automatic predict_sample(input logic signed [H_W-1:0] h4);
		int rate, ncols, col;
		longint h1, h2, h3, h4l, a10, a01, a11, den, num;
		logic signed [H_W-1:0] above;
		up_point_t pt;
		rate = int'(rate_reg);
		if (rate < 1)
			rate = 1;
		else if (rate > MAX_RATE)
			rate = MAX_RATE;
		ncols = int'(cols_reg);
		if (ncols < 2)
			ncols = 2;
		else if (ncols > MAX_COLS)
			ncols = MAX_COLS;
		col = int'(raster_col);
		above = prev_row_mem[raster_col];
		if (raster_row != '0 && col >= 1) begin
			h1  = upleft_h;
			h2  = above;
			h3  = left_h;
			h4l = h4;
			a10 = h2 - h1;
			a01 = h3 - h1;
			a11 = h1 - h2 - h3 + h4l;
			den = rate * rate;
			for (int bi = 0; bi < rate; bi++) begin
				for (int bj = 0; bj < rate; bj++) begin
					num = h1 * den + a10 * bj * rate + a01 * bi * rate + a11 * bi * bj;
					pt.h    = H_W'(num / den);
					pt.row  = UP_W'(rate * (int'(raster_row) - 1) + bi);
					pt.col  = UP_W'(rate * (col - 1) + bj);
					pt.last = (bi == rate - 1) && (bj == rate - 1);
					expected_points.push_back(pt);
				end
			end
		end
		prev_row_mem[raster_col] = h4;
		upleft_h = above;
		left_h = h4;
		if (col + 1 >= ncols) begin
			raster_col = '0;
			raster_row = raster_row + 1'b1;
		end else begin
			raster_col = raster_col + 1'b1;
		end
	endtask

	function automatic logic signed [H_W-1:0] next_height(input height_mode_t mode);
		logic signed [H_W-1:0] v;
		case (mode)
			HM_EXTREME: begin
				case ($urandom_range(0, 4))
					0:       v = 16'sh7FFF;
					1:       v = 16'sh8000;
					2:       v = 16'sh0000;
					3:       v = 16'shFFFF;
					default: v = H_W'($urandom);
				endcase
			end
			HM_WALK: begin
				walk_h = walk_h + int'($urandom_range(0, 512)) - 256;
				if (walk_h > 32767)
					walk_h = 32767;
				else if (walk_h < -32768)
					walk_h = -32768;
				v = H_W'(walk_h);
			end
			default: v = H_W'($urandom);
		endcase
		return v;
	endfunction

	// one sample transfer; bursts of random length with random gaps between them
	task automatic send_sample(input logic signed [H_W-1:0] h);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk) in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		height   <= h;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_sample(h);
	endtask

	// drop valid, wait for every pending point, then let the last sample settle
	task automatic settle_idle();
		@(negedge clk) in_valid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_COLS_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_RATE: rate_reg = data[RATE_W-1:0];
			REG_COLS: cols_reg = data;
			default: ;
		endcase
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// reset values: rate 2 and a first row longer than the stored span, which
	// loads every line store entry that later rows read; then a row cut short
	task automatic test_power_on_defaults();
		repeat (FILL_COLS) send_sample(next_height(HM_WALK));
		settle_idle();
		// below the minimum and below the current column: the next transfer wraps
		write_reg(REG_COLS, 13'd1);
		repeat (5) send_sample(next_height(HM_UNIFORM));
	endtask

	task automatic test_corner_extremes();
		logic signed [H_W-1:0] corners [0:9];
		corners = '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000,
			16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'shFFFF};
		settle_idle();
		write_reg(REG_RATE, 13'd15);
		write_reg(REG_COLS, 13'd2);
		foreach (corners[i])
			send_sample(corners[i]);
		settle_idle();
		// only the low four bits land in the rate
		write_reg(REG_RATE, 13'h1FF3);
		repeat (4) send_sample(next_height(HM_EXTREME));
		settle_idle();
		write_reg(REG_RATE, 13'd9);
		repeat (2) send_sample(next_height(HM_EXTREME));
		settle_idle();
		// a zero rate acts as one
		write_reg(REG_RATE, 13'd0);
		repeat (2) send_sample(next_height(HM_EXTREME));
		settle_idle();
		write_reg(REG_RATE, 13'd1);
		repeat (2) send_sample(next_height(HM_UNIFORM));
		settle_idle();
		// unused indexes must leave both registers alone
		write_reg(REG_SPARE_A, 13'd0);
		write_reg(REG_SPARE_B, 13'h1FFF);
		repeat (4) send_sample(next_height(HM_UNIFORM));
	endtask

	// long receiver hold-off while samples keep coming, then a full drain
	task automatic test_backpressure();
		settle_idle();
		write_reg(REG_RATE, 13'd4);
		write_reg(REG_COLS, 13'd5);
		hold_left = 400;
		repeat (30) send_sample(next_height(HM_WALK));
		settle_idle();
		repeat (20) send_sample(next_height(HM_UNIFORM));
	endtask

	task automatic test_random_raster();
		int total, n, sel, rate_data, cols_data;
		height_mode_t mode;
		total = 0;
		while (total < RANDOM_ITEMS) begin
			settle_idle();
			sel = $urandom_range(0, 15);
			if (sel < 10)
				rate_data = $urandom_range(1, 4);
			else if (sel < 13)
				rate_data = $urandom_range(5, 8);
			else
				rate_data = ($urandom_range(0, 511) << 4) | $urandom_range(0, 15);
			if ($urandom_range(0, 4) != 0)
				write_reg(REG_RATE, CFG_COLS_W'(rate_data));
			// row lengths stay within the span loaded by the first row
			sel = $urandom_range(0, 15);
			if (sel < 10)
				cols_data = $urandom_range(2, 9);
			else if (sel < 14)
				cols_data = $urandom_range(0, FILL_COLS);
			else
				cols_data = $urandom_range(0, 1);
			if ($urandom_range(0, 4) != 0)
				write_reg(REG_COLS, CFG_COLS_W'(cols_data));
			mode = height_mode_t'($urandom_range(0, 2));
			n = $urandom_range(25, 50);
			repeat (n) send_sample(next_height(mode));
			total += n;
		end
	endtask

	// receiver: forced hold-off when asked, otherwise a stall pattern of its own
	initial begin
		int pat_left, pat_mode;
		pat_left = 0;
		pat_mode = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				if (pat_left == 0) begin
					pat_left = $urandom_range(4, 40);
					pat_mode = $urandom_range(0, 3);
				end
				pat_left--;
				case (pat_mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 3) == 0);
					2:       out_stall <= 1'($urandom_range(0, 1));
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		up_point_t want, got;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			got = '{h: up_height, row: up_row, col: up_col, last: last_of_cell};
			if (expected_points.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$error("unexpected transfer up_height %0d up_row %0d up_col %0d",
						got.h, got.row, got.col);
			end else begin
				want = expected_points.pop_front();
				if (got.h !== want.h) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$error("up_height expected %0d actual %0d", want.h, got.h);
				end
				if (got.row !== want.row) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$error("up_row expected %0d actual %0d", want.row, got.row);
				end
				if (got.col !== want.col) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$error("up_col expected %0d actual %0d", want.col, got.col);
				end
				if (got.last !== want.last) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$error("last_of_cell expected %0d actual %0d", want.last, got.last);
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_power_on_defaults();
		test_corner_extremes();
		test_backpressure();
		test_random_raster();
		settle_idle();
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#(1_500_000 * 2 * CLK_HALF);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/bgu_pkg.sv
rtl/bgu_line_store.sv
rtl/bgu_cell_seq.sv
rtl/bgu_div.sv
rtl/bilinear_grid_upsampler.sv
tb/tb_bilinear_grid_upsampler.sv
